### design/uart_rb_pkg.sv
// ============================================================================
// uart_rb_pkg
// Shared types, constants and helpers of the serial port ring buffer block.
// ============================================================================
package uart_rb_pkg;

    // Ring geometry.
    localparam int RING_DEPTH = 8;
    localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    // Field widths of the stream payloads.
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 3;
    localparam int LEVEL_W = 4;
    localparam int OUT_DATA_W = 24;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PUT      = 3'd0,
        OP_TX_READY = 3'd1,
        OP_RX_BYTE  = 3'd2,
        OP_GET      = 3'd3,
        OP_FLUSH_TX = 3'd4,
        OP_FLUSH_RX = 3'd5
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted operation
        logic execute;   // update rings and issue the store read
        logic load;      // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

    // Ring pointer advance with wrap at the ring depth.
    function automatic t_ptr next_ptr(input t_ptr p);
        t_ptr r;
        if (p == PTR_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

### design/uart_tx_rx_ring_buffers_unit.sv
// ============================================================================
// uart_tx_rx_ring_buffers_unit
// Transmit and receive ring buffers of a serial port behind stream channels.
// ============================================================================
// Usage: each transfer on the s_axis channel carries one operation (tuser)
// and one byte (tdata): put a byte into the transmit ring, transmitter ready,
// byte received from the line, get a received byte, flush transmit, flush
// receive. Every operation yields exactly one result transfer on m_axis.
// The result carries the popped byte with its valid flag (tuser), the
// refused-put and overwritten-byte flags, both ring levels and the transmit
// service enable as they stand after the operation.
// Sequence: an accepted operation is latched, then executed on the rings,
// then its result is loaded into the output register; the registered read
// of the ring stores is why the execute step comes before the load.
// The input is ready again right after the result is handed to the output
// register, so a new operation can be taken while the result still waits.
// If m_axis_tready stays low, the next operation is executed but held until
// the output register is free, and s_axis_tready stays low meanwhile.
// Reset (synchronous, active low) empties both rings, clears the service
// enable and drops any pending result; the ring stores are not cleared.
// ============================================================================
module uart_tx_rx_ring_buffers_unit
    import uart_rb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_in [7:0]
    input  logic [BYTE_W-1:0]     s_axis_tdata,
    // op [2:0]
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_byte [7:0], put_refused [8], rx_dropped [9], tx_level [13:10],
    // rx_level [17:14], tx_irq_on [18], zero [23:19]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // out_valid [0]
    output logic                  m_axis_tuser
);

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [BYTE_W-1:0]  out_byte;
    logic               put_refused;
    logic               rx_dropped;
    logic [LEVEL_W-1:0] tx_level;
    logic [LEVEL_W-1:0] rx_level;
    logic               tx_irq_on;

    // Sequencing of one operation at a time.
    uart_rb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // Rings and result register.
    uart_rb_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (s_axis_tuser),
        .i_data        (s_axis_tdata),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_byte    (out_byte),
        .o_byte_valid  (m_axis_tuser),
        .o_put_refused (put_refused),
        .o_rx_dropped  (rx_dropped),
        .o_tx_level    (tx_level),
        .o_rx_level    (rx_level),
        .o_tx_irq_on   (tx_irq_on)
    );

    // Result packing, highest field first.
    assign m_axis_tdata = {
        (OUT_DATA_W - BYTE_W - 3 - 2 * LEVEL_W)'(0),
        tx_irq_on, rx_level, tx_level, rx_dropped, put_refused, out_byte
    };

    // The controller issues at most one command per cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.capture, cmd.execute, cmd.load}))
        else $error("controller issued overlapping commands");

    // An accepted operation is executed in the following cycle.
    a_exec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> cmd.execute)
        else $error("accepted operation was not executed");

    // No new operation is taken between execution and result load.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.execute |=> !s_axis_tready)
        else $error("input ready while a result is pending");

    // A refused put never returns a byte.
    a_refuse_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser && put_refused))
        else $error("refused put reported a popped byte");

endmodule

### design/uart_rb_ctrl.sv
// ============================================================================
// uart_rb_ctrl
// Controller state machine: accepts one operation, runs it through the
// datapath and hands the result to the output register.
// ============================================================================
module uart_rb_ctrl
    import uart_rb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LOAD = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // No transfer is taken while reset is held.
                s_axis_tready = i_rst_n;
                if (s_axis_tvalid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = ST_LOAD;
            end
            ST_LOAD: begin
                // Wait here while the previous result is still unclaimed.
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/uart_rb_dp.sv
// ============================================================================
// uart_rb_dp
// Datapath: transmit and receive ring stores, their pointers and fill counts,
// the transmit service enable and the registered result.
// ============================================================================
module uart_rb_dp
    import uart_rb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_put_refused,
    output logic              o_rx_dropped,
    output logic [LEVEL_W-1:0] o_tx_level,
    output logic [LEVEL_W-1:0] o_rx_level,
    output logic              o_tx_irq_on
);

    // Latched operation.
    logic [OP_W-1:0]   r_op;
    logic [BYTE_W-1:0] r_data;

    // Ring stores.
    logic [BYTE_W-1:0] r_tx_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rx_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_tx_rd;
    logic [BYTE_W-1:0] r_rx_rd;

    // Ring control state.
    t_ptr r_tx_rp, n_tx_rp, r_tx_wp, n_tx_wp;
    t_ptr r_rx_rp, n_rx_rp, r_rx_wp, n_rx_wp;
    t_cnt r_tx_fill, n_tx_fill, r_rx_fill, n_rx_fill;
    logic r_tx_en, n_tx_en;

    // Per-operation flags, valid from execute until load.
    logic r_pop, n_pop;
    logic r_pop_rx, n_pop_rx;
    logic r_refused, n_refused;
    logic r_dropped, n_dropped;

    logic tx_wr_en;
    logic rx_wr_en;

    // Output register.
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_byte_valid;
    logic              r_put_refused;
    logic              r_rx_dropped;
    logic [LEVEL_W-1:0] r_tx_level;
    logic [LEVEL_W-1:0] r_rx_level;
    logic              r_tx_irq_on;

    // Capture of the accepted operation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_data <= i_data;
        end
    end

    // Ring update for the latched operation.
    always_comb begin
        n_tx_rp   = r_tx_rp;
        n_tx_wp   = r_tx_wp;
        n_tx_fill = r_tx_fill;
        n_rx_rp   = r_rx_rp;
        n_rx_wp   = r_rx_wp;
        n_rx_fill = r_rx_fill;
        n_tx_en   = r_tx_en;
        n_pop     = 1'b0;
        n_pop_rx  = 1'b0;
        n_refused = 1'b0;
        n_dropped = 1'b0;
        tx_wr_en  = 1'b0;
        rx_wr_en  = 1'b0;
        case (r_op)
            OP_PUT: begin
                if (r_tx_fill == CNT_W'(RING_DEPTH)) begin
                    n_refused = 1'b1;
                end else begin
                    tx_wr_en  = 1'b1;
                    n_tx_wp   = next_ptr(r_tx_wp);
                    n_tx_fill = r_tx_fill + CNT_W'(1);
                    n_tx_en   = 1'b1;
                end
            end
            OP_TX_READY: begin
                if (r_tx_en) begin
                    if (r_tx_fill != '0) begin
                        n_pop     = 1'b1;
                        n_tx_rp   = next_ptr(r_tx_rp);
                        n_tx_fill = r_tx_fill - CNT_W'(1);
                    end
                    // The enable drops once the ring has run dry.
                    if (r_tx_fill <= CNT_W'(1)) begin
                        n_tx_en = 1'b0;
                    end
                end
            end
            OP_RX_BYTE: begin
                rx_wr_en = 1'b1;
                n_rx_wp  = next_ptr(r_rx_wp);
                if (r_rx_fill != CNT_W'(RING_DEPTH)) begin
                    n_rx_fill = r_rx_fill + CNT_W'(1);
                end else begin
                    // Full ring: the oldest unread byte is overwritten.
                    n_rx_rp   = next_ptr(r_rx_rp);
                    n_dropped = 1'b1;
                end
            end
            OP_GET: begin
                if (r_rx_fill != '0) begin
                    n_pop     = 1'b1;
                    n_pop_rx  = 1'b1;
                    n_rx_rp   = next_ptr(r_rx_rp);
                    n_rx_fill = r_rx_fill - CNT_W'(1);
                end
            end
            OP_FLUSH_TX: begin
                n_tx_rp   = '0;
                n_tx_wp   = '0;
                n_tx_fill = '0;
            end
            OP_FLUSH_RX: begin
                n_rx_rp   = '0;
                n_rx_wp   = '0;
                n_rx_fill = '0;
            end
            default: begin
            end
        endcase
    end

    // Ring control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rp   <= '0;
            r_tx_wp   <= '0;
            r_tx_fill <= '0;
            r_rx_rp   <= '0;
            r_rx_wp   <= '0;
            r_rx_fill <= '0;
            r_tx_en   <= 1'b0;
        end else if (i_cmd.execute) begin
            r_tx_rp   <= n_tx_rp;
            r_tx_wp   <= n_tx_wp;
            r_tx_fill <= n_tx_fill;
            r_rx_rp   <= n_rx_rp;
            r_rx_wp   <= n_rx_wp;
            r_rx_fill <= n_rx_fill;
            r_tx_en   <= n_tx_en;
        end
    end

    // Operation flags held for the load step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_pop     <= n_pop;
            r_pop_rx  <= n_pop_rx;
            r_refused <= n_refused;
            r_dropped <= n_dropped;
        end
    end

    // Transmit store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && tx_wr_en) begin
            r_tx_mem[r_tx_wp] <= r_data;
        end
        if (i_cmd.execute) begin
            r_tx_rd <= r_tx_mem[r_tx_rp];
        end
    end

    // Receive store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && rx_wr_en) begin
            r_rx_mem[r_rx_wp] <= r_data;
        end
        if (i_cmd.execute) begin
            r_rx_rd <= r_rx_mem[r_rx_rp];
        end
    end

    // Output register valid: set on load, cleared when the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!r_pop) begin
                r_out_byte <= '0;
            end else if (r_pop_rx) begin
                r_out_byte <= r_rx_rd;
            end else begin
                r_out_byte <= r_tx_rd;
            end
            r_byte_valid  <= r_pop;
            r_put_refused <= r_refused;
            r_rx_dropped  <= r_dropped;
            r_tx_level    <= LEVEL_W'(r_tx_fill);
            r_rx_level    <= LEVEL_W'(r_rx_fill);
            r_tx_irq_on   <= r_tx_en;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_put_refused = r_put_refused;
    assign o_rx_dropped  = r_rx_dropped;
    assign o_tx_level    = r_tx_level;
    assign o_rx_level    = r_rx_level;
    assign o_tx_irq_on   = r_tx_irq_on;

endmodule

### sim/uart_tx_rx_ring_buffers_unit_test.sv
// ============================================================================
// uart_tx_rx_ring_buffers_unit_test
// Self-checking testbench for the serial port transmit and receive rings.
// Each accepted operation is run through a cycle-free model of both rings
// and the service enable; the expected result is queued and compared field
// by field with every result transfer. Directed cases cover the empty, full,
// overwrite and flush corners and one long receiver hold-off, then biased
// random traffic runs with random idle cycles on both channels.
// ============================================================================
module uart_tx_rx_ring_buffers_unit_test;
    import uart_rb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes that the block does not define.
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int MAX_GAP       = 19;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SEGMENT_ITEMS = 50;

    // One result transfer, split into its fields.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               put_refused;
        logic               rx_dropped;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
        logic               tx_irq_on;
    } t_ring_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // Model state of both rings.
    logic [BYTE_W-1:0] tx_ring [RING_DEPTH];
    logic [BYTE_W-1:0] rx_ring [RING_DEPTH];
    t_ptr              tx_rd = '0;
    t_ptr              tx_wr = '0;
    t_cnt              tx_count = '0;
    t_ptr              rx_rd = '0;
    t_ptr              rx_wr = '0;
    t_cnt              rx_count = '0;
    logic              tx_enable = 1'b0;

    t_ring_result pending_results[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           gaps_off = 1'b0;
    int           hold_request = 0;

    uart_tx_rx_ring_buffers_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock.
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return gaps_off ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_ptr wrap_inc(input t_ptr p);
        return (p == t_ptr'(RING_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    // Applies one operation to the model rings and returns its result.
    function automatic t_ring_result apply_uart_op(input logic [OP_W-1:0] op,
                                                   input logic [BYTE_W-1:0] data);
        t_ring_result r;
        r = '0;
        case (op)
            OP_PUT: begin
                if (tx_count >= RING_DEPTH) begin
                    r.put_refused = 1'b1;
                end else begin
                    tx_ring[tx_wr] = data;
                    tx_wr = wrap_inc(tx_wr);
                    tx_count = tx_count + t_cnt'(1);
                    tx_enable = 1'b1;
                end
            end
            OP_TX_READY: begin
                // Ignored unless the service enable is set.
                if (tx_enable) begin
                    if (tx_count != 0) begin
                        r.out_byte = tx_ring[tx_rd];
                        r.out_valid = 1'b1;
                        tx_rd = wrap_inc(tx_rd);
                        tx_count = tx_count - t_cnt'(1);
                    end
                    if (tx_count == 0) begin
                        tx_enable = 1'b0;
                    end
                end
            end
            OP_RX_BYTE: begin
                // A full ring loses its oldest byte.
                rx_ring[rx_wr] = data;
                rx_wr = wrap_inc(rx_wr);
                if (rx_count < RING_DEPTH) begin
                    rx_count = rx_count + t_cnt'(1);
                end else begin
                    rx_rd = wrap_inc(rx_rd);
                    r.rx_dropped = 1'b1;
                end
            end
            OP_GET: begin
                if (rx_count != 0) begin
                    r.out_byte = rx_ring[rx_rd];
                    r.out_valid = 1'b1;
                    rx_rd = wrap_inc(rx_rd);
                    rx_count = rx_count - t_cnt'(1);
                end
            end
            OP_FLUSH_TX: begin
                tx_rd = '0;
                tx_wr = '0;
                tx_count = '0;
            end
            OP_FLUSH_RX: begin
                rx_rd = '0;
                rx_wr = '0;
                rx_count = '0;
            end
            default: begin
            end
        endcase
        r.tx_level = LEVEL_W'(tx_count);
        r.rx_level = LEVEL_W'(rx_count);
        r.tx_irq_on = tx_enable;
        return r;
    endfunction

    // Sends one operation and records its expected result on acceptance.
    // Valid is left high so that a back-to-back item needs no second drive.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        do begin
            @(posedge i_clk);
        end while (!(s_axis_tvalid && s_axis_tready));
        pending_results.push_back(apply_uart_op(op, data));
    endtask

    // Receiver: per-result random stall, plus a long hold-off on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                stall_left = draw_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s at cycle %0d: expected 0x%0h, got 0x%0h",
                     what, cycle_count, exp_val, act_val);
        end
    endtask

    // Result checker: each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result", 0, int'(m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.out_byte)
                    note_mismatch("out_byte", want.out_byte, m_axis_tdata[7:0]);
                if (m_axis_tuser !== want.out_valid)
                    note_mismatch("out_valid", want.out_valid, m_axis_tuser);
                if (m_axis_tdata[8] !== want.put_refused)
                    note_mismatch("put_refused", want.put_refused, m_axis_tdata[8]);
                if (m_axis_tdata[9] !== want.rx_dropped)
                    note_mismatch("rx_dropped", want.rx_dropped, m_axis_tdata[9]);
                if (m_axis_tdata[13:10] !== want.tx_level)
                    note_mismatch("tx_level", want.tx_level, m_axis_tdata[13:10]);
                if (m_axis_tdata[17:14] !== want.rx_level)
                    note_mismatch("rx_level", want.rx_level, m_axis_tdata[17:14]);
                if (m_axis_tdata[18] !== want.tx_irq_on)
                    note_mismatch("tx_irq_on", want.tx_irq_on, m_axis_tdata[18]);
                if (m_axis_tdata[23:19] !== 5'd0)
                    note_mismatch("padding", 0, m_axis_tdata[23:19]);
            end
        end
    end

    // Empty-ring corners and the undefined op codes.
    task automatic test_empty_cases();
        send_op(OP_GET, 8'h00);
        send_op(OP_TX_READY, 8'hFF);
        send_op(OP_SPARE6, 8'h3C);
        send_op(OP_SPARE7, 8'hC3);
    endtask

    // Fill the transmit ring, refuse one more, pop, then flush with the
    // enable still set so that the next ready finds an empty ring.
    task automatic test_tx_full_and_flush();
        logic [BYTE_W-1:0] fill_bytes [RING_DEPTH];
        fill_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h81, 8'h7E};
        for (int i = 0; i < RING_DEPTH; i++) begin
            send_op(OP_PUT, fill_bytes[i]);
        end
        send_op(OP_PUT, 8'h99);
        send_op(OP_TX_READY, 8'h00);
        send_op(OP_FLUSH_TX, 8'hFF);
        send_op(OP_TX_READY, 8'h00);
    endtask

    // Overrun the receive ring, read one back, then flush it.
    task automatic test_rx_overwrite();
        for (int i = 0; i <= RING_DEPTH; i++) begin
            send_op(OP_RX_BYTE, (i[0]) ? 8'hFF - BYTE_W'(i) : BYTE_W'(i));
        end
        send_op(OP_GET, 8'hA5);
        send_op(OP_FLUSH_RX, 8'h5A);
    endtask

    // Receiver stops for a long stretch while the sender keeps offering,
    // so that the block backs up and holds off its input.
    task automatic test_receiver_hold();
        gaps_off = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            case (i % 4)
                0: send_op(OP_PUT, BYTE_W'($urandom_range(0, 255)));
                1: send_op(OP_RX_BYTE, BYTE_W'($urandom_range(0, 255)));
                2: send_op(OP_GET, BYTE_W'($urandom_range(0, 255)));
                default: send_op(OP_TX_READY, BYTE_W'($urandom_range(0, 255)));
            endcase
        end
        gaps_off = 1'b0;
    endtask

    // Random traffic in segments, each with its own fill bias so that the
    // rings swing between empty and full; some segments run without gaps.
    task automatic test_random_traffic(input int n_items);
        int put_pct;
        int rxw_pct;
        int pick;
        logic [OP_W-1:0] op;
        put_pct = 50;
        rxw_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % SEGMENT_ITEMS == 0) begin
                put_pct = 25 * $urandom_range(1, 3);
                rxw_pct = 25 * $urandom_range(1, 3);
                gaps_off = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                op = OP_FLUSH_TX;
            end else if (pick < 4) begin
                op = OP_FLUSH_RX;
            end else if (pick < 6) begin
                op = ($urandom_range(0, 1) != 0) ? OP_SPARE7 : OP_SPARE6;
            end else if (pick < 53) begin
                op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_TX_READY;
            end else begin
                op = ($urandom_range(0, 99) < rxw_pct) ? OP_RX_BYTE : OP_GET;
            end
            send_op(op, BYTE_W'($urandom_range(0, 255)));
        end
        gaps_off = 1'b0;
    endtask

    // Main sequence.
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_cases();
        test_tx_full_and_flush();
        test_rx_overwrite();
        test_receiver_hold();
        test_random_traffic(RANDOM_ITEMS);
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
